// ===== rtl/core/salc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the set-associative LRU cache tag model.
// No dependencies; imported by the channel interfaces and the core.
package salc_pkg;

  localparam int ADDR_W  = 64;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SET_INDEX_BITS = 2'd0;
  localparam cfg_idx_t CFG_OFFSET_BITS    = 2'd1;
  localparam cfg_idx_t CFG_WAYS_IN_USE    = 2'd2;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

endpackage

// ===== rtl/core/salc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: access request, lookup result and config write.
// Depends on salc_pkg.
interface salc_req_if;
  import salc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] access_address;
  modport source (output valid, output access_address, input ready);
  modport sink (input valid, input access_address, output ready);
endinterface

interface salc_rsp_if;
  import salc_pkg::*;
  logic             valid;
  logic             ready;
  outcome_t         outcome;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;
  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output eviction_total, input ready);
  modport sink (input valid, input outcome, input hit_total, input miss_total,
                input eviction_total, output ready);
endinterface

interface salc_cfg_if;
  import salc_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/set_assoc_lru_cache_tag_model_core.sv =====
`timescale 1ns / 1ps
// Set-associative cache tag lookup with LRU replacement and saturating counters.
// Depends on salc_pkg and the channel interfaces in salc_if.
//
//  channel | dir | transaction
//  --------+-----+----------------------------------------------------------
//  req     | in  | access_address
//  rsp     | out | outcome, hit_total, miss_total, eviction_total
//  cfg     | in  | index, data (register write, always ready)
//
// The set row is read from the tag memory into a register at accept, then
// looked up, updated and written back once the result register is free.
// Reset clears per-set row flags at once; no clearing pass is needed.
// A full result register holds the lookup state until rsp is taken.
module set_assoc_lru_cache_tag_model_core #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic         clk,
  input  logic         rst,
  salc_req_if.sink     req,
  salc_rsp_if.source   rsp,
  salc_cfg_if.sink     cfg
);
  import salc_pkg::*;

  localparam int MAX_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = 5;

  typedef line_t [MAX_WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t state;

  logic [2:0] set_index_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_in_use;

  row_t              mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_init;

  row_t               rd_row;
  logic               row_init_q;
  logic [ADDR_W-1:0]  tag_q;
  logic [SET_W-1:0]   set_q;
  logic [WCNT_W-1:0]  ways_q;

  logic [STAMP_W-1:0] access_order;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   miss_count;
  logic [CNT_W-1:0]   eviction_count;

  logic rsp_valid;
  outcome_t rsp_outcome;

  // Address split
  logic               accept;
  logic [2:0]         sbits;
  logic [6:0]         tag_shift;
  logic [ADDR_W-1:0]  req_tag;
  logic [ADDR_W-1:0]  set_full;
  logic [SET_W-1:0]   set_mask;
  logic [SET_W-1:0]   req_set;
  logic [WCNT_W-1:0]  ways_eff;

  assign accept = req.valid && req.ready;

  always_comb begin
    sbits = (32'(set_index_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_index_bits;
    tag_shift = 7'(offset_bits) + 7'(sbits);
    req_tag = tag_shift[6] ? '0 : (req.access_address >> tag_shift[5:0]);
    set_full = req.access_address >> offset_bits;
    set_mask = ~({SET_W{1'b1}} << sbits);
    req_set = set_full[SET_W-1:0] & set_mask;
    if (ways_in_use == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_in_use);
    end
  end

  // Lookup
  logic               fin;
  logic               hit_found;
  logic [WAY_W-1:0]   hit_way;
  logic               free_found;
  logic [WAY_W-1:0]   free_way;
  logic [WAY_W-1:0]   victim;
  logic [WAY_W-1:0]   target;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] vld;
  logic [STAMP_W-1:0] order_next;
  row_t               new_row;
  outcome_t           res_outcome;
  logic [CNT_W-1:0]   hit_next;
  logic [CNT_W-1:0]   miss_next;
  logic [CNT_W-1:0]   evict_next;

  assign fin = (state == ST_LOOKUP) && (!rsp_valid || rsp.ready);
  assign order_next = access_order + 1'b1;

  always_comb begin
    hit_found  = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    victim     = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (w < 32'(ways_q));
      vld[w]    = row_init_q && rd_row[w].valid;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit_found && in_use[w] && vld[w] && rd_row[w].tag == tag_q) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (!free_found && in_use[w] && !vld[w]) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && rd_row[w].stamp < rd_row[victim].stamp) begin
        victim = WAY_W'(w);
      end
    end

    hit_next   = hit_count;
    miss_next  = miss_count;
    evict_next = eviction_count;
    if (hit_found) begin
      target      = hit_way;
      res_outcome = OUT_HIT;
      hit_next    = sat_inc(hit_count);
    end else if (free_found) begin
      target      = free_way;
      res_outcome = OUT_FILL;
      miss_next   = sat_inc(miss_count);
    end else begin
      target      = victim;
      res_outcome = OUT_EVICT;
      miss_next   = sat_inc(miss_count);
      evict_next  = sat_inc(eviction_count);
    end

    new_row = rd_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_row[w].valid = vld[w];
    end
    new_row[target].valid = 1'b1;
    new_row[target].tag   = tag_q;
    new_row[target].stamp = order_next;
  end

  // Tag memory
  always_ff @(posedge clk) begin
    if (fin) begin
      mem[set_q] <= new_row;
    end
    if (accept) begin
      rd_row <= mem[req_set];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_q  <= req_tag;
      set_q  <= req_set;
      ways_q <= ways_eff;
    end
    if (fin) begin
      rsp_outcome        <= res_outcome;
      rsp.hit_total      <= hit_next;
      rsp.miss_total     <= miss_next;
      rsp.eviction_total <= evict_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      set_index_bits <= 3'd0;
      offset_bits    <= 6'd0;
      ways_in_use    <= 4'd1;
      row_init       <= '0;
      row_init_q     <= 1'b0;
      access_order   <= '0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_SET_INDEX_BITS: set_index_bits <= cfg.data[2:0];
          CFG_OFFSET_BITS:    offset_bits    <= cfg.data[5:0];
          CFG_WAYS_IN_USE:    ways_in_use    <= cfg.data[3:0];
          default: ;
        endcase
      end
      if (accept) begin
        row_init_q <= row_init[req_set];
      end
      if (fin) begin
        row_init[set_q] <= 1'b1;
        access_order    <= order_next;
        hit_count       <= hit_next;
        miss_count      <= miss_next;
        eviction_count  <= evict_next;
        rsp_valid       <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (fin) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready   = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = rsp_valid;
  assign rsp.outcome = rsp_outcome;

`ifndef SYNTHESIS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOKUP) && !req.ready)
    else $error("accepted transaction did not enter lookup");

  a_evict_full_set: assert property (@(posedge clk) disable iff (rst)
    (fin && res_outcome == OUT_EVICT) |-> ((vld | ~in_use) == '1))
    else $error("eviction while a way in use is free");

  a_fin_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fin |=> rsp.valid)
    else $error("finished lookup produced no response");
`endif

endmodule
